// ----- rtl/spc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spc_pkg: shared types for the semiprime counter
// Payload widths and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int IN_W  = 17;
    localparam int OUT_W = 17;

    typedef struct packed {
        logic start;      // load bound, top, clear index and sum
        logic clr_wr;     // flag clear sweep write, index++
        logic p_init;     // outer prime = 2
        logic p_inc;      // outer prime++
        logic sq_flag;    // square outer prime, read its flag
        logic q_load;     // multiple = p*p
        logic q_step;     // strike multiple, multiple += p
        logic pack_init;  // index = 2, list count = 0, i = 0
        logic pack_rd;    // read flag at index
        logic pack_chk;   // append index if prime, index++
        logic list_rd_i;  // read list entry i
        logic sq_list;    // latch list prime, square it
        logic div_start;  // start (bound-1)/p, open search window
        logic div_step;   // one quotient bit
        logic bs_rd;      // latch mid, read list at mid
        logic bs_upd;     // narrow search window
        logic acc;        // add count, i++
        logic out_load;   // load result register
    } spc_cmd_t;

    typedef struct packed {
        logic short_bound;
        logic idx_at_top;
        logic psq_gt_top;
        logic flag_bit;
        logic q_gt_top;
        logic top_lt2;
        logic i_end;
        logic psq_ge_bound;
        logic div_done;
        logic bs_go;
        logic out_free;
    } spc_sts_t;

endpackage
`default_nettype wire

// ----- rtl/spc_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spc_req_if: request channel
// Valid/ready channel carrying one bound per transfer.
// ----------------------------------------------------------------------------
interface spc_req_if;
    logic        valid;
    logic        ready;
    logic [16:0] limit_val;

    modport source (output valid, output limit_val, input ready);
    modport sink   (input valid, input limit_val, output ready);
endinterface
`default_nettype wire

// ----- rtl/spc_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spc_rsp_if: response channel
// Valid/ready channel carrying one semiprime count per transfer.
// ----------------------------------------------------------------------------
interface spc_rsp_if;
    logic        valid;
    logic        ready;
    logic [16:0] semiprime_total;

    modport source (output valid, output semiprime_total, input ready);
    modport sink   (input valid, input semiprime_total, output ready);
endinterface
`default_nettype wire

// ----- rtl/spc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spc_ctrl: semiprime counter controller
// Sequences flag clear, sieve, list pack, and per-prime divide and search.
// ----------------------------------------------------------------------------
module spc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               idle,
    output spc_pkg::spc_cmd_t  cmd,
    input  spc_pkg::spc_sts_t  sts
);
    import spc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_OUTER  = 4'd2;
    localparam logic [3:0] S_OCHK   = 4'd3;
    localparam logic [3:0] S_INNER  = 4'd4;
    localparam logic [3:0] S_PACK   = 4'd5;
    localparam logic [3:0] S_PACKW  = 4'd6;
    localparam logic [3:0] S_CNT    = 4'd7;
    localparam logic [3:0] S_PRD    = 4'd8;
    localparam logic [3:0] S_PCHK   = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;
    localparam logic [3:0] S_BS     = 4'd11;
    localparam logic [3:0] S_BSW    = 4'd12;
    localparam logic [3:0] S_FINISH = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign idle = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = sts.short_bound ? S_FINISH : S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.idx_at_top)
                begin
                    cmd.p_init = 1'b1;
                    state_next = S_OUTER;
                end
            end
            S_OUTER:
            begin
                cmd.sq_flag = 1'b1;
                state_next  = S_OCHK;
            end
            S_OCHK:
            begin
                if (sts.psq_gt_top)
                begin
                    cmd.pack_init = 1'b1;
                    state_next    = sts.top_lt2 ? S_CNT : S_PACK;
                end
                else if (sts.flag_bit)
                begin
                    cmd.q_load = 1'b1;
                    state_next = S_INNER;
                end
                else
                begin
                    cmd.p_inc  = 1'b1;
                    state_next = S_OUTER;
                end
            end
            S_INNER:
            begin
                if (sts.q_gt_top)
                begin
                    cmd.p_inc  = 1'b1;
                    state_next = S_OUTER;
                end
                else
                begin
                    cmd.q_step = 1'b1;
                end
            end
            S_PACK:
            begin
                cmd.pack_rd = 1'b1;
                state_next  = S_PACKW;
            end
            S_PACKW:
            begin
                cmd.pack_chk = 1'b1;
                state_next   = sts.idx_at_top ? S_CNT : S_PACK;
            end
            S_CNT:
            begin
                if (sts.i_end)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.list_rd_i = 1'b1;
                    state_next    = S_PRD;
                end
            end
            S_PRD:
            begin
                cmd.sq_list = 1'b1;
                state_next  = S_PCHK;
            end
            S_PCHK:
            begin
                if (sts.psq_ge_bound)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_BS;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_BS:
            begin
                if (sts.bs_go)
                begin
                    cmd.bs_rd  = 1'b1;
                    state_next = S_BSW;
                end
                else
                begin
                    cmd.acc    = 1'b1;
                    state_next = S_CNT;
                end
            end
            S_BSW:
            begin
                cmd.bs_upd = 1'b1;
                state_next = S_BS;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/spc_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spc_dpath: semiprime counter datapath
// Flag and prime list memories, counters, squarer, serial divider, result reg.
// ----------------------------------------------------------------------------
module spc_dpath #(
    parameter int MAX_LIMIT   = 65536,
    parameter int PRIME_SLOTS = 4096
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  spc_pkg::spc_cmd_t  cmd,
    output spc_pkg::spc_sts_t  sts,
    input  wire logic [16:0]   req_bound,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output logic [16:0]        semiprime_total
);
    import spc_pkg::*;

    localparam int LW   = $clog2(MAX_LIMIT + 1);
    localparam int CW   = (LW > IN_W) ? LW : IN_W;
    localparam int FD   = MAX_LIMIT / 2 + 1;
    localparam int FAW  = $clog2(FD);
    localparam int QW   = FAW + 1;
    localparam int PW   = 2 * FAW;
    localparam int SAW  = $clog2(PRIME_SLOTS);
    localparam int CTW  = SAW + 1;
    localparam int MW   = CTW + 1;
    localparam int RW   = LW + 1;
    localparam int DCW  = $clog2(LW + 1);

    logic [LW-1:0]    bound_reg;
    logic [FAW-1:0]   top_reg;
    logic [QW-1:0]    idx_reg;
    logic [FAW-1:0]   p_reg;
    logic [QW-1:0]    q_reg;
    logic [PW-1:0]    psq_reg;
    logic [CTW-1:0]   cnt_reg;
    logic [CTW-1:0]   i_reg;
    logic [CTW-1:0]   lo_reg;
    logic [CTW-1:0]   hi_reg;
    logic [CTW-1:0]   mid_reg;
    logic [LW-1:0]    rem_reg;
    logic [LW-1:0]    quo_reg;
    logic [DCW-1:0]   dcnt_reg;
    logic [OUT_W-1:0] sum_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_valid_reg;

    logic             flag_mem [FD];
    logic             flag_q;
    logic [FAW-1:0]   list_mem [PRIME_SLOTS];
    logic [FAW-1:0]   list_q;

    logic [CW-1:0]    ub_ext;
    logic [LW-1:0]    bound_in;
    logic [LW-1:0]    bound_m1;
    logic [FAW-1:0]   fl_raddr;
    logic [SAW-1:0]   ls_raddr;
    logic [CTW-1:0]   mid_next;
    logic [FAW-1:0]   mul_a;
    logic [RW-1:0]    rem_sh;
    logic             rem_ge;

    assign ub_ext   = CW'(req_bound);
    assign bound_in = (ub_ext > CW'(MAX_LIMIT)) ? LW'(MAX_LIMIT) : LW'(ub_ext);
    assign bound_m1 = bound_in - LW'(1);
    assign fl_raddr = cmd.sq_flag ? p_reg : idx_reg[FAW-1:0];
    assign mid_next = CTW'((MW'(lo_reg) + MW'(hi_reg)) >> 1);
    assign ls_raddr = cmd.bs_rd ? mid_next[SAW-1:0] : i_reg[SAW-1:0];
    assign mul_a    = cmd.sq_list ? list_q : p_reg;
    assign rem_sh   = {rem_reg, quo_reg[LW-1]};
    assign rem_ge   = rem_sh >= RW'(p_reg);

    assign sts.short_bound  = bound_in < LW'(4);
    assign sts.idx_at_top   = idx_reg == QW'(top_reg);
    assign sts.psq_gt_top   = psq_reg > PW'(top_reg);
    assign sts.flag_bit     = flag_q;
    assign sts.q_gt_top     = q_reg > QW'(top_reg);
    assign sts.top_lt2      = top_reg < FAW'(2);
    assign sts.i_end        = i_reg >= cnt_reg;
    assign sts.psq_ge_bound = psq_reg >= PW'(bound_reg);
    assign sts.div_done     = dcnt_reg == '0;
    assign sts.bs_go        = lo_reg < hi_reg;
    assign sts.out_free     = !out_valid_reg || rsp_ready;

    assign rsp_valid       = out_valid_reg;
    assign semiprime_total = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            flag_mem[idx_reg[FAW-1:0]] <= (idx_reg >= QW'(2));
        end
        else if (cmd.q_step)
        begin
            flag_mem[q_reg[FAW-1:0]] <= 1'b0;
        end
        if (cmd.sq_flag || cmd.pack_rd)
        begin
            flag_q <= flag_mem[fl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pack_chk && flag_q && (cnt_reg < CTW'(PRIME_SLOTS)))
        begin
            list_mem[cnt_reg[SAW-1:0]] <= idx_reg[FAW-1:0];
        end
        if (cmd.list_rd_i || cmd.bs_rd)
        begin
            list_q <= list_mem[ls_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            bound_reg <= bound_in;
            top_reg   <= FAW'(bound_m1 >> 1);
            idx_reg   <= '0;
            sum_reg   <= '0;
        end
        if (cmd.clr_wr || cmd.pack_chk)
        begin
            idx_reg <= idx_reg + QW'(1);
        end
        if (cmd.p_init)
        begin
            p_reg <= FAW'(2);
        end
        if (cmd.p_inc)
        begin
            p_reg <= p_reg + FAW'(1);
        end
        if (cmd.sq_flag || cmd.sq_list)
        begin
            psq_reg <= PW'(mul_a) * PW'(mul_a);
        end
        if (cmd.sq_list)
        begin
            p_reg <= list_q;
        end
        if (cmd.q_load)
        begin
            q_reg <= QW'(psq_reg);
        end
        if (cmd.q_step)
        begin
            q_reg <= q_reg + QW'(p_reg);
        end
        if (cmd.pack_init)
        begin
            idx_reg <= QW'(2);
            cnt_reg <= '0;
            i_reg   <= '0;
        end
        if (cmd.pack_chk && flag_q && (cnt_reg < CTW'(PRIME_SLOTS)))
        begin
            cnt_reg <= cnt_reg + CTW'(1);
        end
        if (cmd.div_start)
        begin
            rem_reg  <= '0;
            quo_reg  <= bound_reg - LW'(1);
            dcnt_reg <= DCW'(LW);
            lo_reg   <= i_reg;
            hi_reg   <= cnt_reg;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? LW'(rem_sh - RW'(p_reg)) : LW'(rem_sh);
            quo_reg  <= {quo_reg[LW-2:0], rem_ge};
            dcnt_reg <= dcnt_reg - DCW'(1);
        end
        if (cmd.bs_rd)
        begin
            mid_reg <= mid_next;
        end
        if (cmd.bs_upd)
        begin
            if (LW'(list_q) <= quo_reg)
            begin
                lo_reg <= mid_reg + CTW'(1);
            end
            else
            begin
                hi_reg <= mid_reg;
            end
        end
        if (cmd.acc)
        begin
            sum_reg <= sum_reg + OUT_W'(lo_reg - i_reg);
            i_reg   <= i_reg + CTW'(1);
        end
        if (cmd.out_load)
        begin
            out_data_reg <= sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/semiprime_counter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// semiprime_counter: count semiprimes below a bound
// Sieve into a flag memory, pack primes into a list, then divide and
// binary-search once per prime p with p*p below the bound.
// ----------------------------------------------------------------------------
//  channel  dir  payload                   transfer when
//  req      in   limit_val[16:0]           req.valid & req.ready
//  rsp      out  semiprime_total[16:0]     rsp.valid & rsp.ready
//
//  One request at a time; req.ready is high only while idle. A request runs
//  the flag clear, the sieve strikes for each sieving prime, the pack, and a
//  divide and search per small prime. The flag memory is single-port, with
//  one access per cycle. Bounds below 4 skip straight to the result. The
//  result register lets a new request in while rsp is stalled. Reset clears
//  the controller and rsp.valid only.
// ----------------------------------------------------------------------------
module semiprime_counter #(
    parameter int MAX_LIMIT   = 65536,
    parameter int PRIME_SLOTS = 4096
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    spc_req_if.sink     req,
    spc_rsp_if.source   rsp
);
    import spc_pkg::*;

    spc_cmd_t cmd;
    spc_sts_t sts;
    logic     idle;

    assign req.ready = idle;

    spc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .idle      (idle),
        .cmd       (cmd),
        .sts       (sts)
    );

    spc_dpath #(
        .MAX_LIMIT   (MAX_LIMIT),
        .PRIME_SLOTS (PRIME_SLOTS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .req_bound       (req.limit_val),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .semiprime_total (rsp.semiprime_total)
    );

endmodule
`default_nettype wire
